### rtl/tmseq_pkg.sv
`default_nettype none

package tmseq_pkg;

  // Action codes carried by each request
  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_START  = 3'd1;
  localparam logic [2:0] ACT_STOP   = 3'd2;
  localparam logic [2:0] ACT_FOLD   = 3'd3;
  localparam logic [2:0] ACT_UNFOLD = 3'd4;

  typedef enum logic [2:0] {
    MODE_PENDING   = 3'd0,
    MODE_RUN       = 3'd1,
    MODE_STOPPING  = 3'd2,
    MODE_STOPPED   = 3'd3,
    MODE_FOLDING   = 3'd4,
    MODE_UNFOLDING = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    SEQ_MAIN   = 2'd0,
    SEQ_FOLD   = 2'd1,
    SEQ_UNFOLD = 2'd2
  } seq_t;

  localparam int STEP_W  = 4;
  localparam int MOTOR_W = 10;
  localparam int WORD_W  = 17;
  localparam int MS_W    = 13;

  localparam logic [WORD_W-1:0] LIGHT_BIT = 17'h10000;

  localparam int MAIN_LEN   = 14;
  localparam int FOLD_LEN   = 5;
  localparam int UNFOLD_LEN = 4;

  localparam int MAIN_IDX_W   = $clog2(MAIN_LEN);
  localparam int FOLD_IDX_W   = $clog2(FOLD_LEN);
  localparam int UNFOLD_IDX_W = $clog2(UNFOLD_LEN);

  // Longest step duration over all sequences, in milliseconds
  localparam int MAX_MS = 4500;

  localparam logic [MOTOR_W-1:0] MAIN_CMD [MAIN_LEN] = '{
    10'h000, 10'h001, 10'h004, 10'h1A4, 10'h100, 10'h002, 10'h000,
    10'h001, 10'h200, 10'h058, 10'h040, 10'h010, 10'h008, 10'h002
  };
  localparam logic [MS_W-1:0] MAIN_MS [MAIN_LEN] = '{
    13'd1000, 13'd1400, 13'd2500, 13'd1600, 13'd3000, 13'd1400, 13'd1000,
    13'd1400, 13'd4400, 13'd1600, 13'd175, 13'd120, 13'd2240, 13'd1200
  };

  localparam logic [MOTOR_W-1:0] FOLD_CMD [FOLD_LEN] = '{
    10'h000, 10'h002, 10'h068, 10'h020, 10'h040
  };
  localparam logic [MS_W-1:0] FOLD_MS [FOLD_LEN] = '{
    13'd0, 13'd100, 13'd4500, 13'd200, 13'd800
  };

  localparam logic [MOTOR_W-1:0] UNFOLD_CMD [UNFOLD_LEN] = '{
    10'h000, 10'h010, 10'h080, 10'h094
  };
  localparam logic [MS_W-1:0] UNFOLD_MS [UNFOLD_LEN] = '{
    13'd0, 13'd200, 13'd850, 13'd4500
  };

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] now_time;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] command_word;
    logic [2:0]        mode_after;
  } out_t;

  typedef struct packed {
    logic emit;
    out_t result;
  } step_res_t;

endpackage

`default_nettype wire

### rtl/tmseq_rom.sv
`default_nettype none

module tmseq_rom #(
  parameter int unsigned TICK_FREQ = 32768
) (
  input  var tmseq_pkg::seq_t                   seq,
  input  wire logic [tmseq_pkg::STEP_W-1:0]     idx,
  output logic [tmseq_pkg::MOTOR_W-1:0]         motor,
  output logic [63:0]                           ticks
);

  localparam logic [63:0] MaxTicks =
    64'(tmseq_pkg::MAX_MS) * 64'(TICK_FREQ) / 64'd1000;
  localparam int TickW = $clog2(MaxTicks + 64'd1);

  logic [TickW-1:0] main_ticks   [tmseq_pkg::MAIN_LEN];
  logic [TickW-1:0] fold_ticks   [tmseq_pkg::FOLD_LEN];
  logic [TickW-1:0] unfold_ticks [tmseq_pkg::UNFOLD_LEN];
  logic [TickW-1:0] ticks_sel;

  // Step durations in clock ticks, settled at elaboration
  for (genvar i = 0; i < tmseq_pkg::MAIN_LEN; i++) begin : g_main
    localparam logic [63:0] T = 64'(tmseq_pkg::MAIN_MS[i]) * 64'(TICK_FREQ) / 64'd1000;
    assign main_ticks[i] = TickW'(T);
  end
  for (genvar i = 0; i < tmseq_pkg::FOLD_LEN; i++) begin : g_fold
    localparam logic [63:0] T = 64'(tmseq_pkg::FOLD_MS[i]) * 64'(TICK_FREQ) / 64'd1000;
    assign fold_ticks[i] = TickW'(T);
  end
  for (genvar i = 0; i < tmseq_pkg::UNFOLD_LEN; i++) begin : g_unfold
    localparam logic [63:0] T = 64'(tmseq_pkg::UNFOLD_MS[i]) * 64'(TICK_FREQ) / 64'd1000;
    assign unfold_ticks[i] = TickW'(T);
  end

  always_comb begin
    unique case (seq)
      tmseq_pkg::SEQ_FOLD: begin
        motor     = tmseq_pkg::FOLD_CMD[idx[tmseq_pkg::FOLD_IDX_W-1:0]];
        ticks_sel = fold_ticks[idx[tmseq_pkg::FOLD_IDX_W-1:0]];
      end
      tmseq_pkg::SEQ_UNFOLD: begin
        motor     = tmseq_pkg::UNFOLD_CMD[idx[tmseq_pkg::UNFOLD_IDX_W-1:0]];
        ticks_sel = unfold_ticks[idx[tmseq_pkg::UNFOLD_IDX_W-1:0]];
      end
      default: begin
        motor     = tmseq_pkg::MAIN_CMD[idx[tmseq_pkg::MAIN_IDX_W-1:0]];
        ticks_sel = main_ticks[idx[tmseq_pkg::MAIN_IDX_W-1:0]];
      end
    endcase
  end

  assign ticks = 64'(ticks_sel);

endmodule

`default_nettype wire

### rtl/tmseq_core.sv
`default_nettype none

module tmseq_core #(
  parameter int unsigned TICK_FREQ = 32768
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  fire,
  input  var tmseq_pkg::in_t         req,
  output tmseq_pkg::step_res_t       res
);

  tmseq_pkg::mode_t                  mode;
  logic [tmseq_pkg::STEP_W-1:0]      step_index;
  logic [63:0]                       deadline;

  tmseq_pkg::mode_t                  mode_next;
  logic [tmseq_pkg::STEP_W-1:0]      step_index_next;
  logic [63:0]                       deadline_next;

  tmseq_pkg::mode_t                  mode_req;
  logic [tmseq_pkg::STEP_W-1:0]      step_req;
  logic [63:0]                       dl_req;

  tmseq_pkg::seq_t                   seq;
  logic [tmseq_pkg::STEP_W:0]        seq_len;
  logic [tmseq_pkg::STEP_W:0]        step_inc;
  logic [tmseq_pkg::STEP_W-1:0]      step_adv;
  logic [tmseq_pkg::MOTOR_W-1:0]     motor;
  logic [63:0]                       ticks;
  logic                              due;

  tmseq_rom #(.TICK_FREQ(TICK_FREQ)) u_rom (
    .seq   (seq),
    .idx   (step_adv),
    .motor (motor),
    .ticks (ticks)
  );

  // Apply the request's mode change first
  always_comb begin
    mode_req = mode;
    step_req = step_index;
    dl_req   = deadline;
    unique case (req.action)
      tmseq_pkg::ACT_START: begin
        if (mode == tmseq_pkg::MODE_STOPPED) mode_req = tmseq_pkg::MODE_PENDING;
      end
      tmseq_pkg::ACT_STOP: begin
        if (mode == tmseq_pkg::MODE_RUN) mode_req = tmseq_pkg::MODE_STOPPING;
      end
      tmseq_pkg::ACT_FOLD, tmseq_pkg::ACT_UNFOLD: begin
        if (mode == tmseq_pkg::MODE_STOPPED) begin
          mode_req = (req.action == tmseq_pkg::ACT_FOLD) ? tmseq_pkg::MODE_FOLDING
                                                         : tmseq_pkg::MODE_UNFOLDING;
          step_req = '0;
          dl_req   = '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (mode_req)
      tmseq_pkg::MODE_FOLDING: begin
        seq     = tmseq_pkg::SEQ_FOLD;
        seq_len = (tmseq_pkg::STEP_W+1)'(tmseq_pkg::FOLD_LEN);
      end
      tmseq_pkg::MODE_UNFOLDING: begin
        seq     = tmseq_pkg::SEQ_UNFOLD;
        seq_len = (tmseq_pkg::STEP_W+1)'(tmseq_pkg::UNFOLD_LEN);
      end
      default: begin
        seq     = tmseq_pkg::SEQ_MAIN;
        seq_len = (tmseq_pkg::STEP_W+1)'(tmseq_pkg::MAIN_LEN);
      end
    endcase
  end

  // Wrap to step 0 at or past the end of the sequence
  assign step_inc = {1'b0, step_req} + 1'b1;
  assign step_adv = (step_inc >= seq_len) ? '0 : step_inc[tmseq_pkg::STEP_W-1:0];
  assign due      = req.now_time > dl_req;

  // Run step
  always_comb begin
    mode_next                = mode_req;
    step_index_next          = step_req;
    deadline_next            = dl_req;
    res.emit                 = 1'b0;
    res.result.command_word  = {{(tmseq_pkg::WORD_W-tmseq_pkg::MOTOR_W){1'b0}}, motor};
    unique case (mode_req)
      tmseq_pkg::MODE_PENDING: begin
        step_index_next = '0;
        deadline_next   = '0;
        mode_next       = tmseq_pkg::MODE_RUN;
      end
      tmseq_pkg::MODE_RUN, tmseq_pkg::MODE_STOPPING: begin
        if (due) begin
          step_index_next = step_adv;
          deadline_next   = req.now_time + ticks;
          res.emit        = 1'b1;
          if (mode_req == tmseq_pkg::MODE_RUN) begin
            res.result.command_word = res.result.command_word | tmseq_pkg::LIGHT_BIT;
          end
        end
        if (mode_req == tmseq_pkg::MODE_STOPPING && step_index_next == '0) begin
          mode_next = tmseq_pkg::MODE_STOPPED;
        end
      end
      tmseq_pkg::MODE_FOLDING, tmseq_pkg::MODE_UNFOLDING: begin
        if (due) begin
          step_index_next = step_adv;
          deadline_next   = req.now_time + ticks;
          res.emit        = 1'b1;
          if (step_adv == '0) mode_next = tmseq_pkg::MODE_STOPPED;
        end
      end
      default: ;
    endcase
    res.result.mode_after = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= tmseq_pkg::MODE_STOPPED;
      step_index <= '1;
      deadline   <= '0;
    end else if (fire) begin
      mode       <= mode_next;
      step_index <= step_index_next;
      deadline   <= deadline_next;
    end
  end

endmodule

`default_nettype wire

### rtl/timed_motion_sequencer.sv
`default_nettype none

// Timed motion sequencer for a small arm. Each request carries an action
// (tick, start, stop, fold, unfold) and the current absolute time in clock
// ticks. Start, stop, fold and unfold change the mode only from their
// allowed mode; the block then steps through the main, fold or unfold
// command table once the time is strictly past the current deadline, sets
// the next deadline to now_time + floor(step_ms * TICK_FREQ / 1000)
// and returns the command word (light bit 16 set while running) together
// with the mode left behind. Requests that issue no command give no result.
// Accepts one request per clock while the result slot is free or drains; a
// request passes the input register, then the result register. The core
// path is the 64-bit deadline compare and add plus a small table read; step
// durations in ticks are constants fixed by TICK_FREQ at elaboration.
module timed_motion_sequencer #(
  parameter int unsigned TICK_FREQ = 32768
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  var tmseq_pkg::in_t    in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output tmseq_pkg::out_t       out_data
);

  // Input register: holds one request until the core takes it
  tmseq_pkg::in_t        req;
  logic                  req_full;
  logic                  fire;
  tmseq_pkg::step_res_t  res;

  // The core advances when it holds a request and the result slot is free or drains this cycle
  assign fire     = req_full && (!out_valid || out_ready);
  assign in_ready = !req_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (in_ready) begin
      req_full <= in_valid;
    end
  end

  // Payload: load on every accepted request, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_data;
    end
  end

  tmseq_core #(.TICK_FREQ(TICK_FREQ)) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .req  (req),
    .res  (res)
  );

  // Result register: drop the shown result once taken, load a new one
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && res.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.emit) begin
      out_data <= res.result;
    end
  end

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int TICKS_PER_SEC = 32768;

  // Own copy of the command tables: 10-bit motor word and step length in ms
  localparam logic [9:0] RUN_WORDS [14] = '{
    10'h000, 10'h001, 10'h004, 10'h1A4, 10'h100, 10'h002, 10'h000,
    10'h001, 10'h200, 10'h058, 10'h040, 10'h010, 10'h008, 10'h002
  };
  localparam int RUN_MSEC [14] = '{
    1000, 1400, 2500, 1600, 3000, 1400, 1000,
    1400, 4400, 1600, 175, 120, 2240, 1200
  };
  localparam logic [9:0] TUCK_WORDS [5] = '{10'h000, 10'h002, 10'h068, 10'h020, 10'h040};
  localparam int TUCK_MSEC [5] = '{0, 100, 4500, 200, 800};
  localparam logic [9:0] OPEN_WORDS [4] = '{10'h000, 10'h010, 10'h080, 10'h094};
  localparam int OPEN_MSEC [4] = '{0, 200, 850, 4500};

  // Action codes the block treats as a plain tick
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  // Run shape
  localparam int RANDOM_ITEMS   = 1700;
  localparam int HOLD_AT        = 500;
  localparam int HOLD_CYCLES    = 200;
  localparam int DRAIN_AT       = 1100;
  localparam int CALM_TAIL      = 150;
  localparam int DRAIN_TAIL     = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  // Longer than the longest step (4500 ms), so every flood request is due
  localparam logic [63:0] FLOOD_STEP = 64'd150000;

  typedef enum logic [1:0] {
    ROW_PREDICT,  // expectation comes from the predictor
    ROW_QUIET,    // no result for this request
    ROW_EMITS     // result typed into the row
  } row_kind_t;

  typedef struct packed {
    logic [2:0]       action;
    logic [63:0]      when;
    row_kind_t        kind;
    logic [16:0]      word;
    tmseq_pkg::mode_t mode;
  } script_row_t;

  // Directed opening. Walk from reset through a full main run (start, the
  // stop-at-step-0 shortcut, not-due at equal time, stop with a wrapping
  // deadline), then a full fold and a full unfold.
  localparam script_row_t SCRIPT [28] = '{
    '{ACT_SPARE_LO,          64'd5,     ROW_QUIET,   17'h00000, tmseq_pkg::MODE_STOPPED},
    '{tmseq_pkg::ACT_START,  64'd100,   ROW_QUIET,   17'h00000, tmseq_pkg::MODE_RUN},
    // stop before any step: step index is 0, so drop straight to stopped
    '{tmseq_pkg::ACT_STOP,   64'd0,     ROW_QUIET,   17'h00000, tmseq_pkg::MODE_STOPPED},
    '{tmseq_pkg::ACT_START,  64'd0,     ROW_QUIET,   17'h00000, tmseq_pkg::MODE_RUN},
    '{tmseq_pkg::ACT_TICK,   64'd1,     ROW_EMITS,   17'h10001, tmseq_pkg::MODE_RUN},
    // time equal to the deadline is not due yet
    '{tmseq_pkg::ACT_TICK,   64'd45876, ROW_QUIET,   17'h00000, tmseq_pkg::MODE_RUN},
    '{tmseq_pkg::ACT_TICK,   64'd45877, ROW_EMITS,   17'h10004, tmseq_pkg::MODE_RUN},
    // deadline wraps past the top of the 64-bit range
    '{tmseq_pkg::ACT_STOP,   TIME_MAX,  ROW_EMITS,   17'h001A4, tmseq_pkg::MODE_STOPPING},
    '{tmseq_pkg::ACT_TICK,   64'd52428, ROW_EMITS,   17'h00100, tmseq_pkg::MODE_STOPPING},
    '{tmseq_pkg::ACT_TICK,   TIME_MAX,  ROW_PREDICT, 17'h00000, tmseq_pkg::MODE_STOPPED},
    '{tmseq_pkg::ACT_TICK,   TIME_MAX,  ROW_PREDICT, 17'h00000, tmseq_pkg::MODE_STOPPED},
    '{tmseq_pkg::ACT_TICK,   TIME_MAX,  ROW_PREDICT, 17'h00000, tmseq_pkg::MODE_STOPPED},
    '{tmseq_pkg::ACT_TICK,   TIME_MAX,  ROW_PREDICT, 17'h00000, tmseq_pkg::MODE_STOPPED},
    '{tmseq_pkg::ACT_TICK,   TIME_MAX,  ROW_PREDICT, 17'h00000, tmseq_pkg::MODE_STOPPED},
    '{tmseq_pkg::ACT_TICK,   TIME_MAX,  ROW_PREDICT, 17'h00000, tmseq_pkg::MODE_STOPPED},
    '{tmseq_pkg::ACT_TICK,   TIME_MAX,  ROW_PREDICT, 17'h00000, tmseq_pkg::MODE_STOPPED},
    '{tmseq_pkg::ACT_TICK,   TIME_MAX,  ROW_PREDICT, 17'h00000, tmseq_pkg::MODE_STOPPED},
    '{tmseq_pkg::ACT_TICK,   TIME_MAX,  ROW_PREDICT, 17'h00000, tmseq_pkg::MODE_STOPPED},
    // wrap of the main table while stopping ends the run
    '{tmseq_pkg::ACT_TICK,   TIME_MAX,  ROW_EMITS,   17'h00000, tmseq_pkg::MODE_STOPPED},
    '{tmseq_pkg::ACT_FOLD,   TIME_MAX,  ROW_EMITS,   17'h00002, tmseq_pkg::MODE_FOLDING},
    '{tmseq_pkg::ACT_TICK,   TIME_MAX,  ROW_PREDICT, 17'h00000, tmseq_pkg::MODE_STOPPED},
    '{tmseq_pkg::ACT_TICK,   TIME_MAX,  ROW_PREDICT, 17'h00000, tmseq_pkg::MODE_STOPPED},
    '{tmseq_pkg::ACT_TICK,   TIME_MAX,  ROW_PREDICT, 17'h00000, tmseq_pkg::MODE_STOPPED},
    '{tmseq_pkg::ACT_TICK,   TIME_MAX,  ROW_EMITS,   17'h00000, tmseq_pkg::MODE_STOPPED},
    '{tmseq_pkg::ACT_UNFOLD, TIME_MAX,  ROW_EMITS,   17'h00010, tmseq_pkg::MODE_UNFOLDING},
    '{tmseq_pkg::ACT_TICK,   TIME_MAX,  ROW_PREDICT, 17'h00000, tmseq_pkg::MODE_STOPPED},
    '{tmseq_pkg::ACT_TICK,   TIME_MAX,  ROW_PREDICT, 17'h00000, tmseq_pkg::MODE_STOPPED},
    '{tmseq_pkg::ACT_TICK,   TIME_MAX,  ROW_EMITS,   17'h00000, tmseq_pkg::MODE_STOPPED}
  };

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_ready;
  tmseq_pkg::in_t  in_data;
  logic            out_valid;
  logic            out_ready;
  tmseq_pkg::out_t out_data;

  // Sequencer state as predicted from accepted requests
  tmseq_pkg::mode_t arm_mode;
  logic [3:0]       arm_idx;
  logic [63:0]      arm_due;

  // Results still owed by the block, oldest first
  tmseq_pkg::out_t pending_moves [$];
  tmseq_pkg::out_t want_move;
  int   mismatches = 0;
  int   quiet_cycles = 0;

  // Coordination between the request side and the result side
  logic hold_req    = 1'b0;
  logic hold_served = 1'b0;
  logic calm        = 1'b0;

  timed_motion_sequencer #(
    .TICK_FREQ(TICKS_PER_SEC)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] span_ticks(int msec);
    return (64'(msec) * 64'(TICKS_PER_SEC)) / 64'd1000;
  endfunction

  // Apply one request to the predicted state; report the result it causes.
  function automatic void arm_step(input tmseq_pkg::in_t req, output logic emits,
                                   output tmseq_pkg::out_t res);
    int nxt;
    logic [9:0] word;
    int msec;
    emits = 1'b0;
    res   = '0;
    nxt   = 0;
    word  = '0;
    msec  = 0;

    // Mode requests take effect only from their allowed mode
    case (req.action)
      tmseq_pkg::ACT_START: begin
        if (arm_mode == tmseq_pkg::MODE_STOPPED) arm_mode = tmseq_pkg::MODE_PENDING;
      end
      tmseq_pkg::ACT_STOP: begin
        if (arm_mode == tmseq_pkg::MODE_RUN) arm_mode = tmseq_pkg::MODE_STOPPING;
      end
      tmseq_pkg::ACT_FOLD, tmseq_pkg::ACT_UNFOLD: begin
        if (arm_mode == tmseq_pkg::MODE_STOPPED) begin
          arm_mode = (req.action == tmseq_pkg::ACT_FOLD) ? tmseq_pkg::MODE_FOLDING
                                                         : tmseq_pkg::MODE_UNFOLDING;
          arm_idx  = '0;
          arm_due  = '0;
        end
      end
      default: ;
    endcase

    case (arm_mode)
      tmseq_pkg::MODE_PENDING: begin
        arm_idx  = '0;
        arm_due  = '0;
        arm_mode = tmseq_pkg::MODE_RUN;
      end
      tmseq_pkg::MODE_RUN, tmseq_pkg::MODE_STOPPING: begin
        if (req.now_time > arm_due) begin
          nxt = (int'(arm_idx) + 1 >= $size(RUN_WORDS)) ? 0 : int'(arm_idx) + 1;
          arm_idx = 4'(nxt);
          arm_due = req.now_time + span_ticks(RUN_MSEC[nxt]);
          res.command_word = {7'd0, RUN_WORDS[nxt]};
          if (arm_mode == tmseq_pkg::MODE_RUN) begin
            res.command_word = res.command_word | tmseq_pkg::LIGHT_BIT;
          end
          emits = 1'b1;
        end
        // checked whether or not a step advanced
        if (arm_mode == tmseq_pkg::MODE_STOPPING && arm_idx == '0) begin
          arm_mode = tmseq_pkg::MODE_STOPPED;
        end
      end
      tmseq_pkg::MODE_FOLDING, tmseq_pkg::MODE_UNFOLDING: begin
        if (req.now_time > arm_due) begin
          if (arm_mode == tmseq_pkg::MODE_FOLDING) begin
            nxt  = (int'(arm_idx) + 1 >= $size(TUCK_WORDS)) ? 0 : int'(arm_idx) + 1;
            word = TUCK_WORDS[nxt];
            msec = TUCK_MSEC[nxt];
          end else begin
            nxt  = (int'(arm_idx) + 1 >= $size(OPEN_WORDS)) ? 0 : int'(arm_idx) + 1;
            word = OPEN_WORDS[nxt];
            msec = OPEN_MSEC[nxt];
          end
          arm_idx = 4'(nxt);
          arm_due = req.now_time + span_ticks(msec);
          res.command_word = {7'd0, word};
          emits = 1'b1;
          if (arm_idx == '0) arm_mode = tmseq_pkg::MODE_STOPPED;
        end
      end
      default: ;
    endcase
    res.mode_after = arm_mode;
  endfunction

  // Mostly well-formed traffic for the current mode, with a little noise
  function automatic logic [2:0] pick_action(tmseq_pkg::mode_t m);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    if (r < 9) return 3'($urandom_range(tmseq_pkg::ACT_TICK, tmseq_pkg::ACT_UNFOLD));
    case (m)
      tmseq_pkg::MODE_STOPPED: begin
        case ($urandom_range(0, 3))
          0, 1:    return tmseq_pkg::ACT_START;
          2:       return tmseq_pkg::ACT_FOLD;
          default: return tmseq_pkg::ACT_UNFOLD;
        endcase
      end
      tmseq_pkg::MODE_RUN: begin
        return ($urandom_range(0, 29) == 0) ? tmseq_pkg::ACT_STOP : tmseq_pkg::ACT_TICK;
      end
      default:  return tmseq_pkg::ACT_TICK;
    endcase
  endfunction

  // Move the clock along: hold, small and large steps, going back, jumps
  // anywhere in the 64-bit range and landings just below the top.
  function automatic logic [63:0] next_time(logic [63:0] t);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return t;
    if (r < 70) return t + 64'($urandom_range(0, 60000));
    if (r < 88) return t + 64'($urandom_range(60000, 160000));
    if (r < 93) return t - 64'($urandom_range(1, 50000));
    if (r < 97) return {$urandom, $urandom};
    return TIME_MAX - 64'($urandom_range(0, 200000));
  endfunction

  // Offer one request, hold it until accepted, then predict its result.
  task automatic offer(input tmseq_pkg::in_t req, output logic emits,
                       output tmseq_pkg::out_t res);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    arm_step(req, emits, res);
  endtask

  // Drop valid for a random burst, except while flooding or near the end.
  task automatic maybe_pause();
    if (!calm && !(hold_req && !hold_served) && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Request side
  initial begin
    tmseq_pkg::in_t  req;
    logic            emits;
    tmseq_pkg::out_t res;
    logic [63:0]     t_now;

    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    arm_mode = tmseq_pkg::MODE_STOPPED;
    arm_idx  = '1;
    arm_due  = '0;
    t_now    = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (int k = 0; k < $size(SCRIPT); k++) begin
      req.action   = SCRIPT[k].action;
      req.now_time = SCRIPT[k].when;
      offer(req, emits, res);
      case (SCRIPT[k].kind)
        ROW_EMITS: begin
          res.command_word = SCRIPT[k].word;
          res.mode_after   = SCRIPT[k].mode;
          pending_moves.push_back(res);
        end
        ROW_PREDICT: if (emits) pending_moves.push_back(res);
        default: ;
      endcase
      maybe_pause();
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Stall the result side for a long stretch while requests keep coming
      if (i == HOLD_AT) hold_req <= 1'b1;
      // Hold requests back until every owed result has arrived
      if (i == DRAIN_AT && pending_moves.size() != 0) begin
        in_valid <= 1'b0;
        while (pending_moves.size() != 0) @(posedge clk);
      end
      if (i == RANDOM_ITEMS - CALM_TAIL) calm <= 1'b1;

      if (hold_req && !hold_served) begin
        // Flood: every request is due, so results pile up behind the stall
        req.action = (arm_mode == tmseq_pkg::MODE_STOPPED) ? tmseq_pkg::ACT_START
                                                           : tmseq_pkg::ACT_TICK;
        t_now = t_now + FLOOD_STEP;
      end else begin
        req.action = pick_action(arm_mode);
        t_now = next_time(t_now);
      end
      req.now_time = t_now;
      offer(req, emits, res);
      if (emits) pending_moves.push_back(res);
      maybe_pause();
    end
    in_valid <= 1'b0;

    // Drain, then give the pipeline time to show any stray result
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: random stall bursts, ready stretches, one long hold-off
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served <= 1'b1;
        out_ready   <= 1'b1;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= 1'b1;
            repeat ($urandom_range(20, 80)) @(posedge clk);
          end
          default: out_ready <= 1'b1;
        endcase
      end
    end
  end

  // Compare each accepted result with the oldest one owed
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_moves.size() == 0) begin
        $error("unexpected result: command_word %h mode_after %0d",
               out_data.command_word, out_data.mode_after);
        mismatches++;
      end else begin
        want_move = pending_moves.pop_front();
        if (out_data.command_word !== want_move.command_word) begin
          $error("command_word: expected %h, got %h",
                 want_move.command_word, out_data.command_word);
          mismatches++;
        end
        if (out_data.mode_after !== want_move.mode_after) begin
          $error("mode_after: expected %0d, got %0d",
                 want_move.mode_after, out_data.mode_after);
          mismatches++;
        end
      end
    end
  end

  // Give up when neither side has moved for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

### filelist.f
rtl/tmseq_pkg.sv
rtl/tmseq_rom.sv
rtl/tmseq_core.sv
rtl/timed_motion_sequencer.sv
test/testbench.sv
